// ===== design/bfbp_pkg.sv =====
// ----------------------------------------------------------------------------
// bfbp_pkg
// Types and constants shared by the best-fit buffer pool and its interfaces.
// ----------------------------------------------------------------------------
package bfbp_pkg;

  localparam int CMD_W      = 1;
  localparam int CHANNELS_W = 7;
  localparam int SAMPLES_W  = 16;
  localparam int HANDLE_W   = 5;
  localparam int CAP_W      = 22;
  localparam int STATUS_W   = 2;
  localparam int PROD_W     = CHANNELS_W + SAMPLES_W;

  // handles are carried on a HANDLE_W wide field
  localparam int HANDLE_COUNT = 32;

  localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST = 1'b0,
    CMD_RELEASE = 1'b1
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_HANDLE = 2'd1,
    STATUS_POOL_FULL = 2'd2,
    STATUS_UNISSUED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REQ,
    ST_SCAN,
    ST_COMPACT,
    ST_REL_RD,
    ST_REL_WR,
    ST_RESULT
  } state_t;

endpackage

// ===== design/bfbp_if.sv =====
// ----------------------------------------------------------------------------
// bfbp_req_if / bfbp_rsp_if
// Valid/ready channels for pool commands and their results.
// ----------------------------------------------------------------------------
interface bfbp_req_if;
  logic                               valid;
  logic                               ready;
  logic [bfbp_pkg::CMD_W-1:0]         command;
  logic [bfbp_pkg::CHANNELS_W-1:0]    channels;
  logic [bfbp_pkg::SAMPLES_W-1:0]     samples;
  logic [bfbp_pkg::HANDLE_W-1:0]      handle;

  modport source (output valid, command, channels, samples, handle, input ready);
  modport sink   (input valid, command, channels, samples, handle, output ready);
endinterface

interface bfbp_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [bfbp_pkg::HANDLE_W-1:0]      granted_handle;
  logic [bfbp_pkg::CAP_W-1:0]         capacity;
  logic                               fresh;
  logic [bfbp_pkg::STATUS_W-1:0]      status;

  modport source (output valid, granted_handle, capacity, fresh, status, input ready);
  modport sink   (input valid, granted_handle, capacity, fresh, status, output ready);
endinterface

// ===== design/bfbp_ram.sv =====
// ----------------------------------------------------------------------------
// bfbp_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bfbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/best_fit_buffer_pool.sv =====
// ----------------------------------------------------------------------------
// best_fit_buffer_pool
// Best-fit allocator of buffer handles over an ordered free list.
//
//   channel | dir | fields
//   --------+-----+------------------------------------------------
//   req     | in  | command, channels, samples, handle
//   rsp     | out | granted_handle, capacity, fresh, status
//
// One item at a time. A release of an issued handle passes through a read
// and a write state to its result; an unissued release and a request on an
// empty list go straight to their result. A request over a non-empty free list
// first scans through both memories, then runs a compaction pass.
// Reset clears the state, counters and valid flags; the memories are never cleared.
// A stalled result sits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module best_fit_buffer_pool #(
  parameter int POOL_DEPTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  bfbp_req_if.sink    req,
  bfbp_rsp_if.source  rsp
);

  localparam int PW   = $clog2(POOL_DEPTH);
  localparam int CW   = $clog2(POOL_DEPTH + 1);
  localparam int HW   = $clog2(bfbp_pkg::HANDLE_COUNT);
  localparam int NW   = $clog2(bfbp_pkg::HANDLE_COUNT + 1);
  localparam int CMPW = (NW > bfbp_pkg::HANDLE_W) ? NW : bfbp_pkg::HANDLE_W;
  localparam int CAPW = bfbp_pkg::CAP_W;

  bfbp_pkg::state_t state, state_next;

  logic [bfbp_pkg::HANDLE_W-1:0] cmd_h;
  logic [CAPW-1:0]               need;
  logic [CW-1:0]                 fc;
  logic [NW-1:0]                 next_handle;
  logic [CW-1:0]                 rd_idx;
  logic                          s1_v, s2_v;
  logic [PW-1:0]                 s1_idx, s2_idx;
  logic [HW-1:0]                 s2_h;
  logic [PW-1:0]                 pick_idx;
  logic [HW-1:0]                 pick_h;
  logic [CAPW-1:0]               pick_cap;
  logic                          pick_fits;
  logic                          cv;
  logic [PW-1:0]                 cidx;

  logic [bfbp_pkg::HANDLE_W-1:0] res_h;
  logic [CAPW-1:0]               res_cap;
  logic                          res_fresh;
  bfbp_pkg::status_t             res_status;

  logic                          out_valid;
  logic [bfbp_pkg::HANDLE_W-1:0] out_h;
  logic [CAPW-1:0]               out_cap;
  logic                          out_fresh;
  bfbp_pkg::status_t             out_status;

  logic                          fl_we;
  logic [PW-1:0]                 fl_waddr, fl_raddr;
  logic [HW-1:0]                 fl_wdata, fl_rdata;
  logic                          cap_we;
  logic [HW-1:0]                 cap_waddr, cap_raddr;
  logic [CAPW-1:0]               cap_wdata, cap_rdata;

  logic [bfbp_pkg::PROD_W-1:0]   prod;
  logic                          in_acc;
  logic                          scan_done, compact_done, out_load;
  logic                          c_fits, c_better;

  bfbp_ram #(.WIDTH(HW), .DEPTH(POOL_DEPTH)) u_free_list (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  bfbp_ram #(.WIDTH(CAPW), .DEPTH(bfbp_pkg::HANDLE_COUNT)) u_capacity (
    .clk   (clk),
    .we    (cap_we),
    .waddr (cap_waddr),
    .wdata (cap_wdata),
    .raddr (cap_raddr),
    .rdata (cap_rdata)
  );

  assign req.ready          = (state == bfbp_pkg::ST_IDLE);
  assign in_acc             = req.valid && req.ready;
  assign prod               = bfbp_pkg::PROD_W'(req.channels) * bfbp_pkg::PROD_W'(req.samples);

  assign rsp.valid          = out_valid;
  assign rsp.granted_handle = out_h;
  assign rsp.capacity       = out_cap;
  assign rsp.fresh          = out_fresh;
  assign rsp.status         = out_status;

  assign scan_done    = (rd_idx >= fc) && !s1_v && !s2_v;
  assign compact_done = (rd_idx >= fc) && !cv;
  assign out_load     = (state == bfbp_pkg::ST_RESULT) && (!out_valid || rsp.ready);

  // candidate compare at the end of the scan pipeline
  assign c_fits   = (cap_rdata >= need);
  assign c_better = (s2_idx == '0) ||
                    (c_fits && !pick_fits) ||
                    (c_fits && pick_fits && (cap_rdata < pick_cap)) ||
                    (!c_fits && !pick_fits && (cap_rdata > pick_cap));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    fl_we      = 1'b0;
    fl_waddr   = cidx;
    fl_wdata   = fl_rdata;
    fl_raddr   = rd_idx[PW-1:0];
    cap_we     = 1'b0;
    cap_waddr  = pick_h;
    cap_wdata  = need;
    cap_raddr  = fl_rdata;
    case (state)
      bfbp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (req.command == bfbp_pkg::CMD_RELEASE) begin
            state_next = bfbp_pkg::ST_REL_RD;
          end else begin
            state_next = bfbp_pkg::ST_REQ;
          end
        end
      end
      bfbp_pkg::ST_REQ: begin
        if (fc == '0) begin
          if (CMPW'(next_handle) < CMPW'(bfbp_pkg::HANDLE_COUNT)) begin
            cap_we    = 1'b1;
            cap_waddr = next_handle[HW-1:0];
          end
          state_next = bfbp_pkg::ST_RESULT;
        end else begin
          state_next = bfbp_pkg::ST_SCAN;
        end
      end
      bfbp_pkg::ST_SCAN: begin
        if (scan_done) begin
          cap_we     = !pick_fits;
          state_next = bfbp_pkg::ST_COMPACT;
        end
      end
      bfbp_pkg::ST_COMPACT: begin
        fl_we = cv;
        if (compact_done) begin
          state_next = bfbp_pkg::ST_RESULT;
        end
      end
      bfbp_pkg::ST_REL_RD: begin
        cap_raddr = HW'(cmd_h);
        if (CMPW'(cmd_h) >= CMPW'(next_handle)) begin
          state_next = bfbp_pkg::ST_RESULT;
        end else begin
          state_next = bfbp_pkg::ST_REL_WR;
        end
      end
      bfbp_pkg::ST_REL_WR: begin
        if (fc < CW'(POOL_DEPTH)) begin
          fl_we    = 1'b1;
          fl_waddr = fc[PW-1:0];
          fl_wdata = HW'(cmd_h);
        end
        state_next = bfbp_pkg::ST_RESULT;
      end
      bfbp_pkg::ST_RESULT: begin
        if (out_load) begin
          state_next = bfbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bfbp_pkg::ST_IDLE;
      end
    endcase
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fc          <= '0;
      next_handle <= '0;
    end else begin
      if (state == bfbp_pkg::ST_REQ && fc == '0 &&
          CMPW'(next_handle) < CMPW'(bfbp_pkg::HANDLE_COUNT)) begin
        next_handle <= next_handle + NW'(1);
      end
      if (state == bfbp_pkg::ST_COMPACT && compact_done) begin
        fc <= fc - CW'(1);
      end
      if (state == bfbp_pkg::ST_REL_WR && fc < CW'(POOL_DEPTH)) begin
        fc <= fc + CW'(1);
      end
    end
  end

  // scan and compaction pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      cv   <= 1'b0;
    end else begin
      case (state)
        bfbp_pkg::ST_REQ: begin
          s1_v <= 1'b0;
          s2_v <= 1'b0;
          cv   <= 1'b0;
        end
        bfbp_pkg::ST_SCAN: begin
          s1_v <= (rd_idx < fc);
          s2_v <= s1_v;
        end
        bfbp_pkg::ST_COMPACT: begin
          cv <= (rd_idx < fc);
        end
        default: begin
          s1_v <= 1'b0;
          s2_v <= 1'b0;
          cv   <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_h <= req.handle;
      need  <= prod[bfbp_pkg::PROD_W-1:CAPW] != '0 ? bfbp_pkg::CAP_MAX : prod[CAPW-1:0];
    end
    case (state)
      bfbp_pkg::ST_REQ: begin
        rd_idx <= '0;
        if (CMPW'(next_handle) < CMPW'(bfbp_pkg::HANDLE_COUNT)) begin
          res_h      <= bfbp_pkg::HANDLE_W'(next_handle);
          res_cap    <= need;
          res_fresh  <= 1'b1;
          res_status <= bfbp_pkg::STATUS_OK;
        end else begin
          res_h      <= '0;
          res_cap    <= '0;
          res_fresh  <= 1'b0;
          res_status <= bfbp_pkg::STATUS_NO_HANDLE;
        end
      end
      bfbp_pkg::ST_SCAN: begin
        if (rd_idx < fc) begin
          rd_idx <= rd_idx + CW'(1);
        end
        s1_idx <= rd_idx[PW-1:0];
        s2_idx <= s1_idx;
        s2_h   <= fl_rdata;
        if (s2_v && c_better) begin
          pick_idx  <= s2_idx;
          pick_h    <= s2_h;
          pick_cap  <= cap_rdata;
          pick_fits <= c_fits;
        end
        if (scan_done) begin
          rd_idx     <= CW'(pick_idx) + CW'(1);
          res_h      <= bfbp_pkg::HANDLE_W'(pick_h);
          res_cap    <= pick_fits ? pick_cap : need;
          res_fresh  <= 1'b0;
          res_status <= bfbp_pkg::STATUS_OK;
        end
      end
      bfbp_pkg::ST_COMPACT: begin
        if (rd_idx < fc) begin
          rd_idx <= rd_idx + CW'(1);
          cidx   <= PW'(rd_idx - CW'(1));
        end
      end
      bfbp_pkg::ST_REL_RD: begin
        res_h      <= cmd_h;
        res_cap    <= '0;
        res_fresh  <= 1'b0;
        res_status <= bfbp_pkg::STATUS_UNISSUED;
      end
      bfbp_pkg::ST_REL_WR: begin
        res_cap    <= cap_rdata;
        res_status <= (fc < CW'(POOL_DEPTH)) ? bfbp_pkg::STATUS_OK
                                             : bfbp_pkg::STATUS_POOL_FULL;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_h      <= res_h;
      out_cap    <= res_cap;
      out_fresh  <= res_fresh;
      out_status <= res_status;
    end
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for best_fit_buffer_pool. Requests and releases are
// driven on the req channel. Each accepted item is run through a best-fit
// pool predictor that keeps its own free list, capacity table and issue
// count. Every item on the rsp channel is checked field by field against
// the oldest pending grant. A short directed sequence comes first, then
// bursts of random requests and releases, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_DEPTH    = 16;
  localparam int HANDLE_COUNT  = bfbp_pkg::HANDLE_COUNT;
  localparam int RANDOM_OPS    = 1500;
  localparam int QUIET_OPS     = 200;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct {
    bfbp_pkg::command_t              command;
    logic [bfbp_pkg::CHANNELS_W-1:0] channels;
    logic [bfbp_pkg::SAMPLES_W-1:0]  samples;
    logic [bfbp_pkg::HANDLE_W-1:0]   handle;
  } pool_op_t;

  typedef struct {
    logic [bfbp_pkg::HANDLE_W-1:0] handle;
    logic [bfbp_pkg::CAP_W-1:0]    capacity;
    logic                          fresh;
    bfbp_pkg::status_t             status;
  } grant_t;

  logic clk;
  logic rst;

  bfbp_req_if req_ch ();
  bfbp_rsp_if rsp_ch ();

  best_fit_buffer_pool #(
    .POOL_DEPTH   (POOL_DEPTH)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  pool_op_t ops_to_send[$];
  grant_t   grants_due[$];

  logic [bfbp_pkg::HANDLE_W-1:0] free_handles[POOL_DEPTH];
  int                            free_total;
  logic [bfbp_pkg::CAP_W-1:0]    cap_of[HANDLE_COUNT];
  int                            issued;

  int  fault_count;
  int  cycle_count;
  int  send_gap;
  int  stall_left;
  bit  quiet;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic grant_t serve_op(pool_op_t op);
    grant_t                        g;
    logic [bfbp_pkg::PROD_W-1:0]   prod;
    logic [bfbp_pkg::CAP_W-1:0]    need;
    logic [bfbp_pkg::CAP_W-1:0]    best_cap;
    logic [bfbp_pkg::CAP_W-1:0]    c;
    logic [bfbp_pkg::HANDLE_W-1:0] h;
    bit                            best_fits;
    bit                            fits;
    bit                            better;
    int                            pick;
    g.fresh = 1'b0;
    g.status = bfbp_pkg::STATUS_OK;
    if (op.command == bfbp_pkg::CMD_REQUEST) begin
      prod = op.channels * op.samples;
      need = (prod > bfbp_pkg::PROD_W'(bfbp_pkg::CAP_MAX)) ? bfbp_pkg::CAP_MAX
                                                           : prod[bfbp_pkg::CAP_W-1:0];
      if (free_total == 0) begin
        if (issued >= HANDLE_COUNT) begin
          g.handle = '0;
          g.capacity = '0;
          g.status = bfbp_pkg::STATUS_NO_HANDLE;
        end else begin
          g.handle = bfbp_pkg::HANDLE_W'(issued);
          cap_of[issued] = need;
          issued++;
          g.capacity = need;
          g.fresh = 1'b1;
        end
      end else begin
        pick = 0;
        best_cap = cap_of[free_handles[0]];
        best_fits = best_cap >= need;
        for (int i = 1; i < free_total; i++) begin
          c = cap_of[free_handles[i]];
          fits = c >= need;
          if (fits && !best_fits) better = 1'b1;
          else if (fits && best_fits) better = c < best_cap;
          else if (!fits && !best_fits) better = c > best_cap;
          else better = 1'b0;
          if (better) begin
            pick = i;
            best_cap = c;
            best_fits = fits;
          end
        end
        h = free_handles[pick];
        for (int i = pick; i + 1 < free_total; i++) free_handles[i] = free_handles[i+1];
        free_total--;
        if (cap_of[h] < need) cap_of[h] = need;
        g.handle = h;
        g.capacity = cap_of[h];
      end
    end else begin
      g.handle = op.handle;
      if (op.handle >= issued) begin
        g.capacity = '0;
        g.status = bfbp_pkg::STATUS_UNISSUED;
      end else if (free_total >= POOL_DEPTH) begin
        g.capacity = cap_of[op.handle];
        g.status = bfbp_pkg::STATUS_POOL_FULL;
      end else begin
        free_handles[free_total] = op.handle;
        free_total++;
        g.capacity = cap_of[op.handle];
      end
    end
    return g;
  endfunction

  function automatic pool_op_t request_op(int ch, int s);
    pool_op_t op;
    op.command = bfbp_pkg::CMD_REQUEST;
    op.channels = bfbp_pkg::CHANNELS_W'(ch);
    op.samples = bfbp_pkg::SAMPLES_W'(s);
    op.handle = bfbp_pkg::HANDLE_W'($urandom_range(0, 31));
    return op;
  endfunction

  function automatic pool_op_t release_op(int h);
    pool_op_t op;
    op.command = bfbp_pkg::CMD_RELEASE;
    op.channels = bfbp_pkg::CHANNELS_W'($urandom_range(0, 127));
    op.samples = bfbp_pkg::SAMPLES_W'($urandom_range(0, 65535));
    op.handle = bfbp_pkg::HANDLE_W'(h);
    return op;
  endfunction

  function automatic pool_op_t random_request();
    int ch;
    int s;
    case ($urandom_range(0, 9))
      0: begin ch = 0; s = $urandom_range(0, 65535); end
      1: begin ch = $urandom_range(65, 127); s = $urandom_range(0, 65535); end
      2, 3, 4: begin
        ch = $urandom_range(1, 4);
        case ($urandom_range(0, 5))
          0: s = 16;
          1: s = 32;
          2: s = 64;
          3: s = 100;
          4: s = 128;
          default: s = 256;
        endcase
      end
      5, 6: begin ch = $urandom_range(1, 8); s = $urandom_range(0, 1023); end
      7: begin ch = $urandom_range(0, 127); s = $urandom_range(0, 65535); end
      8: begin ch = 64; s = 65535 - $urandom_range(0, 3); end
      default: begin ch = $urandom_range(0, 127); s = 0; end
    endcase
    return request_op(ch, s);
  endfunction

  task automatic note_mismatch(string field, longint unsigned want, longint unsigned got);
    fault_count++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("best_fit_buffer_pool: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin : drive_ops
    pool_op_t op;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 6);
        req_ch.valid <= 1'b0;
      end else if (ops_to_send.size() != 0) begin
        op = ops_to_send.pop_front();
        req_ch.valid    <= 1'b1;
        req_ch.command  <= op.command;
        req_ch.channels <= op.channels;
        req_ch.samples  <= op.samples;
        req_ch.handle   <= op.handle;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_grants
    grant_t   want;
    pool_op_t op;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (grants_due.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected item handle %0d capacity %0d fresh %0d status %0d",
                   $time, rsp_ch.granted_handle, rsp_ch.capacity, rsp_ch.fresh,
                   rsp_ch.status);
        end else begin
          want = grants_due.pop_front();
          if (rsp_ch.granted_handle !== want.handle)
            note_mismatch("granted_handle", want.handle, rsp_ch.granted_handle);
          if (rsp_ch.capacity !== want.capacity)
            note_mismatch("capacity", want.capacity, rsp_ch.capacity);
          if (rsp_ch.fresh !== want.fresh)
            note_mismatch("fresh", want.fresh, rsp_ch.fresh);
          if (rsp_ch.status !== want.status)
            note_mismatch("status", want.status, rsp_ch.status);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        op.command  = bfbp_pkg::command_t'(req_ch.command);
        op.channels = req_ch.channels;
        op.samples  = req_ch.samples;
        op.handle   = req_ch.handle;
        grants_due.push_back(serve_op(op));
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int kind;
    int len;
    int sent;
    req_ch.valid    = 1'b0;
    req_ch.command  = bfbp_pkg::CMD_REQUEST;
    req_ch.channels = '0;
    req_ch.samples  = '0;
    req_ch.handle   = '0;
    rsp_ch.ready    = 1'b0;
    rst             = 1'b1;
    free_total      = 0;
    issued          = 0;
    fault_count     = 0;
    cycle_count     = 0;
    send_gap        = 0;
    stall_left      = 0;
    quiet           = 1'b0;
    sent            = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // unissued handles, zero need, full-scale and saturated need
    ops_to_send.push_back(release_op(0));
    ops_to_send.push_back(release_op(31));
    ops_to_send.push_back(request_op(0, 0));
    ops_to_send.push_back(request_op(64, 65535));
    ops_to_send.push_back(request_op(127, 65535));
    ops_to_send.push_back(request_op(2, 100));
    ops_to_send.push_back(request_op(1, 200));
    ops_to_send.push_back(request_op(1, 50));
    // free list 3 5 4 0 1: tie between 3 and 4, zero need, growth of largest
    ops_to_send.push_back(release_op(3));
    ops_to_send.push_back(release_op(5));
    ops_to_send.push_back(release_op(4));
    ops_to_send.push_back(release_op(0));
    ops_to_send.push_back(release_op(1));
    ops_to_send.push_back(request_op(1, 150));
    ops_to_send.push_back(request_op(0, 77));
    ops_to_send.push_back(request_op(127, 65535));
    // double release, later fit beats an earlier short one
    ops_to_send.push_back(release_op(5));
    ops_to_send.push_back(request_op(1, 60));
    ops_to_send.push_back(request_op(1, 100));
    ops_to_send.push_back(release_op(6));
    ops_to_send.push_back(request_op(3, 65535));

    // hold off until the pool is quiet
    do @(negedge clk);
    while (ops_to_send.size() != 0 || req_ch.valid || grants_due.size() != 0);

    // use up every handle, then overfill the free list
    repeat (40) ops_to_send.push_back(random_request());
    repeat (20) ops_to_send.push_back(release_op($urandom_range(0, 31)));
    sent = 60;

    while (sent < RANDOM_OPS) begin
      kind = $urandom_range(0, 3);
      len = $urandom_range(1, 20);
      repeat (len) begin
        if (kind == 0 || (kind >= 2 && $urandom_range(0, 1) == 0))
          ops_to_send.push_back(random_request());
        else
          ops_to_send.push_back(release_op($urandom_range(0, 31)));
      end
      sent += len;
    end

    do @(negedge clk);
    while (ops_to_send.size() != 0);
    quiet = 1'b1;
    repeat (QUIET_OPS) begin
      if ($urandom_range(0, 1) == 0) ops_to_send.push_back(random_request());
      else ops_to_send.push_back(release_op($urandom_range(0, 31)));
    end

    do @(negedge clk);
    while (ops_to_send.size() != 0 || req_ch.valid || grants_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (fault_count == 0) begin
      $display("best_fit_buffer_pool: match");
    end else begin
      $display("best_fit_buffer_pool: mismatch");
    end
    $finish;
  end

endmodule
